>>> rtl/iuds_pkg.sv
`timescale 1ns / 1ps

package iuds_pkg;

    // Buffer depth default and the write index limit.
    localparam int BUFFER_BYTES_DEF = 256;
    localparam logic [8:0] WIDX_MAX = 9'd511;

    // Configuration register indexes and reset values.
    localparam logic [7:0] CFG_START = 8'd0;
    localparam logic [7:0] CFG_END   = 8'd1;
    localparam logic [7:0] CFG_BS    = 8'd2;
    localparam logic [7:0] CFG_STMIN = 8'd3;
    localparam logic [31:0] START_RST = 32'd134225920;
    localparam logic [31:0] END_RST   = 32'd134348799;
    localparam logic [7:0]  BS_RST    = 8'd30;
    localparam logic [7:0]  STMIN_RST = 8'd8;

    // ISO-TP frame types.
    localparam logic [3:0] PCI_SINGLE = 4'h0;
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;
    localparam logic [3:0] PCI_FLOW   = 4'h3;
    localparam logic [7:0] FC_CTS      = 8'h30;
    localparam logic [7:0] FC_OVERFLOW = 8'h32;
    localparam logic [11:0] MAX_REQ_LEN = 12'd255;

    // UDS service ids and constants.
    localparam logic [7:0] SID_SESSION = 8'h10;
    localparam logic [7:0] SID_RESET   = 8'h11;
    localparam logic [7:0] SID_READ_ID = 8'h22;
    localparam logic [7:0] SID_REQ_DL  = 8'h34;
    localparam logic [7:0] SID_XFER    = 8'h36;
    localparam logic [7:0] SID_EXIT    = 8'h37;
    localparam logic [7:0] SID_TESTER  = 8'h3E;
    localparam logic [7:0] SID_NEG     = 8'h7F;
    localparam logic [7:0] POS_OFFSET  = 8'h40;
    localparam logic [7:0] SUB_PROG_SESSION = 8'h02;
    localparam logic [7:0] SUB_HARD_RESET   = 8'h01;
    localparam logic [7:0] DID_HI = 8'hF1;
    localparam logic [7:0] DID_LO = 8'h80;
    localparam logic [7:0] ALFID  = 8'h44;
    localparam logic [7:0] P2_TIMING = 8'h0F;
    localparam logic [7:0] LFID   = 8'h10;
    localparam logic [7:0] MAX_BLOCK = 8'hFA;
    localparam logic [31:0] VERSION_ID = 32'h42312D30;

    // Negative response codes.
    localparam logic [7:0] NRC_SUBFUNC  = 8'h12;
    localparam logic [7:0] NRC_LENGTH   = 8'h13;
    localparam logic [7:0] NRC_COND     = 8'h22;
    localparam logic [7:0] NRC_SEQUENCE = 8'h24;
    localparam logic [7:0] NRC_RANGE    = 8'h31;
    localparam logic [7:0] NRC_BLOCK    = 8'h73;
    localparam logic [7:0] NRC_PENDING  = 8'h78;

    // Session states.
    localparam logic [1:0] SESS_NONE   = 2'd0;
    localparam logic [1:0] SESS_ACTIVE = 2'd1;
    localparam logic [1:0] SESS_DL     = 2'd2;

    typedef enum logic [2:0] {
        KIND_TX     = 3'd0,
        KIND_UNLOCK = 3'd1,
        KIND_ERASE  = 3'd2,
        KIND_CHUNK  = 3'd3,
        KIND_EXIT   = 3'd4,
        KIND_RESET  = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0][7:0]  data;
        logic [3:0]       cnt;
        logic [31:0]      addr;
        logic             last;
    } res_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_WDONE,
        OP_FF_START,
        OP_CF_START,
        OP_CLR_EXP,
        OP_STORE,
        OP_SERVE_START,
        OP_SET_S1,
        OP_DL_ACCEPT,
        OP_TD_START,
        OP_CHUNK_RD,
        OP_CHUNK_NEXT,
        OP_FLOW_DONE,
        OP_FINISH
    } op_t;

    // Result selectors for the result builder.
    typedef enum logic [3:0] {
        R_UNLOCK,
        R_SESS,
        R_RESET_ANS,
        R_RESET,
        R_RDID,
        R_ERASE,
        R_DL_ANS,
        R_CHUNK,
        R_EXIT,
        R_TP,
        R_NEG,
        R_FLOW
    } rsel_t;

    typedef struct packed {
        op_t        op;
        logic       emit;
        rsel_t      rsel;
        logic [7:0] nrc;
        logic       neg_frame;
        logic       src_sf;
    } cmd_t;

    typedef struct packed {
        logic       action;
        logic [7:0] b0;
        logic       pending_nz;
        logic       cf_ok;
        logic       store_last;
        logic       serve_ready;
        logic       len_zero;
        logic       rd_idle;
        logic [7:0] sid;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       len_is11;
        logic       len_lt2;
        logic [1:0] session;
        logic       bc_match;
        logic       range_ok;
        logic       chunk_more;
        logic       can_push;
        logic       hold_valid;
    } sts_t;

endpackage

>>> rtl/iuds_ifs.sv
`timescale 1ns / 1ps

// Received frame and write-done channel.
interface iuds_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [7:0] frame_byte6;
    logic [7:0] frame_byte7;
    modport source (output valid, action, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                    frame_byte4, frame_byte5, frame_byte6, frame_byte7, input ready);
    modport sink (input valid, action, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                  frame_byte4, frame_byte5, frame_byte6, frame_byte7, output ready);
endinterface

// Result channel.
interface iuds_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic [7:0]  out_byte4;
    logic [7:0]  out_byte5;
    logic [7:0]  out_byte6;
    logic [7:0]  out_byte7;
    logic [3:0]  byte_count;
    logic [31:0] target_address;
    logic        last;
    modport source (output valid, kind, out_byte0, out_byte1, out_byte2, out_byte3, out_byte4,
                    out_byte5, out_byte6, out_byte7, byte_count, target_address, last,
                    input ready);
    modport sink (input valid, kind, out_byte0, out_byte1, out_byte2, out_byte3, out_byte4,
                  out_byte5, out_byte6, out_byte7, byte_count, target_address, last,
                  output ready);
endinterface

// Configuration write channel.
interface iuds_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/iuds_ram.sv
`timescale 1ns / 1ps

module iuds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/iuds_ctrl.sv
`timescale 1ns / 1ps

module iuds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  iuds_pkg::sts_t  sts,
    output iuds_pkg::cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DECODE   = 14'b00000000000010,
        S_NEG78    = 14'b00000000000100,
        S_STORE    = 14'b00000000001000,
        S_CHECK    = 14'b00000000010000,
        S_SRV      = 14'b00000000100000,
        S_CALC     = 14'b00000001000000,
        S_EXEC     = 14'b00000010000000,
        S_EXEC2    = 14'b00000100000000,
        S_CHK_TEST = 14'b00001000000000,
        S_CHK_WAIT = 14'b00010000000000,
        S_CHK_EMIT = 14'b00100000000000,
        S_FLOW     = 14'b01000000000000,
        S_FINISH   = 14'b10000000000000
    } state_t;

    state_t              state_reg, state_next, nxt;
    logic                ff_item_reg, ff_item_next, ff_d;
    iuds_pkg::rsel_t     rsel2_reg, rsel2_next, rsel2_d;
    iuds_pkg::cmd_t      cmd_d;
    iuds_pkg::cmd_t      cmd_idle;
    state_t              after_s;
    logic                go;

    assign req_ready = (state_reg == S_IDLE);
    assign after_s   = ff_item_reg ? S_FLOW : S_FINISH;

    // Next-state and command decode.
    always_comb
    begin
        cmd_idle.op        = iuds_pkg::OP_NONE;
        cmd_idle.emit      = 1'b0;
        cmd_idle.rsel      = iuds_pkg::R_NEG;
        cmd_idle.nrc       = '0;
        cmd_idle.neg_frame = 1'b0;
        cmd_idle.src_sf    = 1'b0;
        cmd_d   = cmd_idle;
        nxt     = state_reg;
        ff_d    = ff_item_reg;
        rsel2_d = rsel2_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_d.op = iuds_pkg::OP_LATCH;
                    nxt      = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ff_d = 1'b0;
                nxt  = S_FINISH;
                if (sts.action)
                begin
                    cmd_d.op = iuds_pkg::OP_WDONE;
                end
                else
                begin
                    case (sts.b0[7:4])
                        iuds_pkg::PCI_SINGLE:
                        begin
                            if (sts.b0 <= 8'd7)
                            begin
                                cmd_d.op     = iuds_pkg::OP_SERVE_START;
                                cmd_d.src_sf = 1'b1;
                                nxt          = S_SRV;
                            end
                        end
                        iuds_pkg::PCI_FIRST:
                        begin
                            if (sts.pending_nz)
                            begin
                                nxt = S_NEG78;
                            end
                            else
                            begin
                                cmd_d.op = iuds_pkg::OP_FF_START;
                                ff_d     = 1'b1;
                                nxt      = S_STORE;
                            end
                        end
                        iuds_pkg::PCI_CONSEC:
                        begin
                            if (sts.cf_ok)
                            begin
                                cmd_d.op = iuds_pkg::OP_CF_START;
                                nxt      = S_STORE;
                            end
                            else
                            begin
                                cmd_d.op = iuds_pkg::OP_CLR_EXP;
                            end
                        end
                        iuds_pkg::PCI_FLOW:
                        begin
                            cmd_d.op = iuds_pkg::OP_NONE;
                        end
                        default:
                        begin
                            cmd_d.op = iuds_pkg::OP_CLR_EXP;
                        end
                    endcase
                end
            end
            S_NEG78:
            begin
                cmd_d.op        = iuds_pkg::OP_CLR_EXP;
                cmd_d.emit      = 1'b1;
                cmd_d.rsel      = iuds_pkg::R_NEG;
                cmd_d.nrc       = iuds_pkg::NRC_PENDING;
                cmd_d.neg_frame = 1'b1;
                nxt             = S_FINISH;
            end
            S_STORE:
            begin
                cmd_d.op = iuds_pkg::OP_STORE;
                if (sts.store_last)
                begin
                    nxt = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.serve_ready)
                begin
                    cmd_d.op = iuds_pkg::OP_SERVE_START;
                    nxt      = S_SRV;
                end
                else
                begin
                    nxt = after_s;
                end
            end
            S_SRV:
            begin
                if (sts.len_zero)
                begin
                    nxt = after_s;
                end
                else if (sts.rd_idle)
                begin
                    nxt = S_CALC;
                end
            end
            S_CALC:
            begin
                nxt = S_EXEC;
            end
            S_EXEC:
            begin
                cmd_d.emit = 1'b1;
                cmd_d.rsel = iuds_pkg::R_NEG;
                nxt        = after_s;
                unique case (sts.sid)
                    iuds_pkg::SID_SESSION:
                    begin
                        if (sts.b1 == iuds_pkg::SUB_PROG_SESSION)
                        begin
                            cmd_d.op   = iuds_pkg::OP_SET_S1;
                            cmd_d.rsel = iuds_pkg::R_UNLOCK;
                            rsel2_d    = iuds_pkg::R_SESS;
                            nxt        = S_EXEC2;
                        end
                        else
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_SUBFUNC;
                        end
                    end
                    iuds_pkg::SID_RESET:
                    begin
                        if (sts.b1 == iuds_pkg::SUB_HARD_RESET)
                        begin
                            cmd_d.rsel = iuds_pkg::R_RESET_ANS;
                            rsel2_d    = iuds_pkg::R_RESET;
                            nxt        = S_EXEC2;
                        end
                        else
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_COND;
                        end
                    end
                    iuds_pkg::SID_READ_ID:
                    begin
                        if (sts.b1 == iuds_pkg::DID_HI && sts.b2 == iuds_pkg::DID_LO)
                        begin
                            cmd_d.rsel = iuds_pkg::R_RDID;
                        end
                        else
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_RANGE;
                        end
                    end
                    iuds_pkg::SID_REQ_DL:
                    begin
                        if (sts.session != iuds_pkg::SESS_ACTIVE)
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_COND;
                        end
                        else if (!(sts.b1 <= 8'd1 && sts.b2 == iuds_pkg::ALFID))
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_RANGE;
                        end
                        else if (!sts.len_is11)
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_LENGTH;
                        end
                        else if (sts.range_ok)
                        begin
                            cmd_d.op   = iuds_pkg::OP_DL_ACCEPT;
                            cmd_d.rsel = iuds_pkg::R_ERASE;
                            rsel2_d    = iuds_pkg::R_DL_ANS;
                            nxt        = S_EXEC2;
                        end
                        else
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_RANGE;
                        end
                    end
                    iuds_pkg::SID_XFER:
                    begin
                        if (sts.session != iuds_pkg::SESS_DL)
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_SEQUENCE;
                        end
                        else if (sts.len_lt2)
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_LENGTH;
                        end
                        else if (!sts.bc_match)
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_BLOCK;
                        end
                        else
                        begin
                            cmd_d.emit = 1'b0;
                            cmd_d.op   = iuds_pkg::OP_TD_START;
                            nxt        = S_CHK_TEST;
                        end
                    end
                    iuds_pkg::SID_EXIT:
                    begin
                        if (sts.session != iuds_pkg::SESS_DL)
                        begin
                            cmd_d.nrc = iuds_pkg::NRC_SEQUENCE;
                        end
                        else
                        begin
                            cmd_d.rsel = iuds_pkg::R_EXIT;
                        end
                    end
                    iuds_pkg::SID_TESTER:
                    begin
                        cmd_d.rsel = iuds_pkg::R_TP;
                    end
                    default:
                    begin
                        cmd_d.nrc = iuds_pkg::NRC_SUBFUNC;
                    end
                endcase
            end
            S_EXEC2:
            begin
                cmd_d.emit = 1'b1;
                cmd_d.rsel = rsel2_reg;
                nxt        = after_s;
            end
            S_CHK_TEST:
            begin
                if (sts.chunk_more)
                begin
                    cmd_d.op = iuds_pkg::OP_CHUNK_RD;
                    nxt      = S_CHK_WAIT;
                end
                else
                begin
                    nxt = after_s;
                end
            end
            S_CHK_WAIT:
            begin
                if (sts.rd_idle)
                begin
                    nxt = S_CHK_EMIT;
                end
            end
            S_CHK_EMIT:
            begin
                cmd_d.op   = iuds_pkg::OP_CHUNK_NEXT;
                cmd_d.emit = 1'b1;
                cmd_d.rsel = iuds_pkg::R_CHUNK;
                nxt        = S_CHK_TEST;
            end
            S_FLOW:
            begin
                cmd_d.op   = iuds_pkg::OP_FLOW_DONE;
                cmd_d.emit = 1'b1;
                cmd_d.rsel = iuds_pkg::R_FLOW;
                nxt        = S_FINISH;
            end
            S_FINISH:
            begin
                cmd_d.op = iuds_pkg::OP_FINISH;
                nxt      = S_IDLE;
            end
            default:
            begin
                nxt = S_IDLE;
            end
        endcase

        // Hold everything while the result stage cannot take a result.
        go = (!cmd_d.emit && cmd_d.op != iuds_pkg::OP_FINISH) || sts.can_push;
        cmd          = go ? cmd_d : cmd_idle;
        state_next   = go ? nxt : state_reg;
        ff_item_next = go ? ff_d : ff_item_reg;
        rsel2_next   = go ? rsel2_d : rsel2_reg;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ff_item_reg <= 1'b0;
            rsel2_reg   <= iuds_pkg::R_NEG;
        end
        else
        begin
            state_reg   <= state_next;
            ff_item_reg <= ff_item_next;
            rsel2_reg   <= rsel2_next;
        end
    end

endmodule

>>> rtl/iuds_dp.sv
`timescale 1ns / 1ps

module iuds_dp #(
    parameter int BUFFER_BYTES = iuds_pkg::BUFFER_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             action_in,
    input  logic [7:0][7:0]  frame_in,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  iuds_pkg::cmd_t   cmd,
    output iuds_pkg::sts_t   sts,
    output iuds_pkg::res_t   out_res,
    output logic             out_valid,
    input  logic             out_ready
);

    localparam int AW = $clog2(BUFFER_BYTES);

    // Configuration.
    logic [31:0] start_reg, end_reg;
    logic [7:0]  bs_reg, stmin_reg;

    // Latched item.
    logic        action_reg;
    logic [7:0]  frame_reg [8];

    // Protocol state.
    logic [11:0] expected_reg;
    logic [8:0]  widx_reg;
    logic [3:0]  seq_reg;
    logic [1:0]  session_reg;
    logic [7:0]  bc_reg;
    logic [7:0]  pending_reg;
    logic [31:0] waddr_reg;

    // Frame store sequencing.
    logic [2:0]  st_off_reg, st_cnt_reg, st_n_reg;

    // Request being served.
    logic [7:0]  len_reg;
    logic        src_sf_reg;
    logic [7:0]  hdr_reg [11];
    logic        range_ok_reg;

    // Buffer reader.
    logic        rd_busy_reg, rd_hdr_reg, cap_valid_reg;
    logic [3:0]  rd_cnt_reg, rd_total_reg, cap_slot_reg;
    logic [7:0]  rd_base_reg, cap_idx_reg, rd_idx;
    logic [7:0]  cap_data;

    // Write chunk sequencing.
    logic [7:0]  chunk_reg [8];
    logic [3:0]  ck_cnt_reg;
    logic [8:0]  k_reg;
    logic [7:0]  n_reg;
    logic [8:0]  rem;
    logic [3:0]  ck_cnt;

    // Result stages.
    iuds_pkg::res_t hold_reg, out_reg, built, fwd;
    logic           hold_v_reg, out_v_reg, out_free;

    // Buffer memory.
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_q;

    logic [31:0] dl_addr, dl_size;
    logic [32:0] dl_end;
    logic [7:0]  serve_len;

    assign ram_we    = (cmd.op == iuds_pkg::OP_STORE) && (32'(widx_reg) < BUFFER_BYTES);
    assign ram_waddr = AW'(widx_reg);
    assign ram_wdata = frame_reg[st_off_reg + st_cnt_reg];
    assign rd_idx    = rd_base_reg + 8'(rd_cnt_reg);
    assign ram_raddr = AW'(rd_idx);

    iuds_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Read data: a single frame reads its own bytes; the buffer reads zero past its end.
    always_comb
    begin
        if (src_sf_reg)
        begin
            cap_data = (cap_idx_reg < 8'd7) ? frame_reg[cap_idx_reg[2:0] + 3'd1] : 8'h00;
        end
        else
        begin
            cap_data = (32'(cap_idx_reg) < BUFFER_BYTES) ? ram_q : 8'h00;
        end
    end

    assign dl_addr   = {hdr_reg[3], hdr_reg[4], hdr_reg[5], hdr_reg[6]};
    assign dl_size   = {hdr_reg[7], hdr_reg[8], hdr_reg[9], hdr_reg[10]};
    assign dl_end    = {1'b0, dl_addr} + {1'b0, dl_size};
    assign serve_len = cmd.src_sf ? frame_reg[0] : expected_reg[7:0];
    assign rem       = 9'(n_reg) - k_reg;
    assign ck_cnt    = (rem < 9'd8) ? rem[3:0] : 4'd8;
    assign out_free  = !out_v_reg || out_ready;

    // Status toward the controller.
    always_comb
    begin
        sts.action      = action_reg;
        sts.b0          = frame_reg[0];
        sts.pending_nz  = (pending_reg != 8'd0);
        sts.cf_ok       = (seq_reg == frame_reg[0][3:0]) && (expected_reg != 12'd0);
        sts.store_last  = (st_cnt_reg == st_n_reg - 3'd1);
        sts.serve_ready = (12'(widx_reg) >= expected_reg);
        sts.len_zero    = (len_reg == 8'd0);
        sts.rd_idle     = !rd_busy_reg && !cap_valid_reg;
        sts.sid         = hdr_reg[0];
        sts.b1          = hdr_reg[1];
        sts.b2          = hdr_reg[2];
        sts.len_is11    = (len_reg == 8'd11);
        sts.len_lt2     = (len_reg < 8'd2);
        sts.session     = session_reg;
        sts.bc_match    = (bc_reg == hdr_reg[1]);
        sts.range_ok    = range_ok_reg;
        sts.chunk_more  = (k_reg < 9'(n_reg));
        sts.can_push    = !hold_v_reg || out_free;
        sts.hold_valid  = hold_v_reg;
    end

    // Result builder.
    always_comb
    begin
        built      = '0;
        built.kind = iuds_pkg::KIND_TX;
        built.cnt  = 4'd8;
        unique case (cmd.rsel)
            iuds_pkg::R_UNLOCK:
            begin
                built.kind = iuds_pkg::KIND_UNLOCK;
                built.cnt  = 4'd0;
            end
            iuds_pkg::R_SESS:
            begin
                built.data[0] = 8'd6;
                built.data[1] = iuds_pkg::SID_SESSION + iuds_pkg::POS_OFFSET;
                built.data[2] = iuds_pkg::SUB_PROG_SESSION;
                built.data[3] = iuds_pkg::P2_TIMING;
                built.data[4] = iuds_pkg::P2_TIMING;
                built.data[5] = iuds_pkg::P2_TIMING;
                built.data[6] = iuds_pkg::P2_TIMING;
            end
            iuds_pkg::R_RESET_ANS:
            begin
                built.data[0] = 8'd2;
                built.data[1] = iuds_pkg::SID_RESET + iuds_pkg::POS_OFFSET;
                built.data[2] = iuds_pkg::SUB_HARD_RESET;
            end
            iuds_pkg::R_RESET:
            begin
                built.kind = iuds_pkg::KIND_RESET;
                built.cnt  = 4'd0;
            end
            iuds_pkg::R_RDID:
            begin
                built.data[0] = 8'd7;
                built.data[1] = iuds_pkg::SID_READ_ID + iuds_pkg::POS_OFFSET;
                built.data[2] = iuds_pkg::DID_HI;
                built.data[3] = iuds_pkg::DID_LO;
                built.data[4] = iuds_pkg::VERSION_ID[31:24];
                built.data[5] = iuds_pkg::VERSION_ID[23:16];
                built.data[6] = iuds_pkg::VERSION_ID[15:8];
                built.data[7] = iuds_pkg::VERSION_ID[7:0];
            end
            iuds_pkg::R_ERASE:
            begin
                built.kind    = iuds_pkg::KIND_ERASE;
                built.cnt     = 4'd0;
                built.data[0] = hdr_reg[7];
                built.data[1] = hdr_reg[8];
                built.data[2] = hdr_reg[9];
                built.data[3] = hdr_reg[10];
                built.addr    = dl_addr;
            end
            iuds_pkg::R_DL_ANS:
            begin
                built.data[0] = 8'd3;
                built.data[1] = iuds_pkg::SID_REQ_DL + iuds_pkg::POS_OFFSET;
                built.data[2] = iuds_pkg::LFID;
                built.data[3] = iuds_pkg::MAX_BLOCK;
            end
            iuds_pkg::R_CHUNK:
            begin
                built.kind = iuds_pkg::KIND_CHUNK;
                built.cnt  = ck_cnt_reg;
                for (int i = 0; i < 8; i++)
                begin
                    built.data[i] = chunk_reg[i];
                end
                built.addr = waddr_reg + 32'(k_reg);
            end
            iuds_pkg::R_EXIT:
            begin
                built.kind = iuds_pkg::KIND_EXIT;
                built.cnt  = 4'd0;
            end
            iuds_pkg::R_TP:
            begin
                built.data[0] = 8'd2;
                built.data[1] = iuds_pkg::SID_TESTER + iuds_pkg::POS_OFFSET;
            end
            iuds_pkg::R_NEG:
            begin
                built.data[0] = 8'd3;
                built.data[1] = iuds_pkg::SID_NEG;
                built.data[2] = cmd.neg_frame ? frame_reg[2] : hdr_reg[0];
                built.data[3] = cmd.nrc;
            end
            iuds_pkg::R_FLOW:
            begin
                if (expected_reg > iuds_pkg::MAX_REQ_LEN)
                begin
                    built.data[0] = iuds_pkg::FC_OVERFLOW;
                end
                else
                begin
                    built.data[0] = iuds_pkg::FC_CTS;
                    built.data[1] = bs_reg;
                    built.data[2] = stmin_reg;
                end
            end
            default:
            begin
                built.cnt = 4'd0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= iuds_pkg::START_RST;
            end_reg   <= iuds_pkg::END_RST;
            bs_reg    <= iuds_pkg::BS_RST;
            stmin_reg <= iuds_pkg::STMIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iuds_pkg::CFG_START: start_reg <= cfg_data;
                iuds_pkg::CFG_END:   end_reg   <= cfg_data;
                iuds_pkg::CFG_BS:    bs_reg    <= cfg_data[7:0];
                iuds_pkg::CFG_STMIN: stmin_reg <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // Protocol state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            widx_reg     <= '0;
            seq_reg      <= '0;
            session_reg  <= iuds_pkg::SESS_NONE;
            bc_reg       <= '0;
            pending_reg  <= '0;
            waddr_reg    <= '0;
            st_off_reg   <= '0;
            st_cnt_reg   <= '0;
            st_n_reg     <= '0;
            len_reg      <= '0;
            src_sf_reg   <= 1'b0;
            k_reg        <= '0;
            n_reg        <= '0;
            ck_cnt_reg   <= '0;
        end
        else
        begin
            unique case (cmd.op)
                iuds_pkg::OP_WDONE:
                begin
                    if (pending_reg != 8'd0)
                    begin
                        bc_reg      <= bc_reg + 8'd1;
                        waddr_reg   <= waddr_reg + 32'(pending_reg);
                        pending_reg <= '0;
                    end
                end
                iuds_pkg::OP_FF_START:
                begin
                    expected_reg <= {frame_reg[0][3:0], frame_reg[1]};
                    widx_reg     <= '0;
                    seq_reg      <= 4'd1;
                    st_off_reg   <= 3'd2;
                    st_cnt_reg   <= 3'd0;
                    st_n_reg     <= 3'd6;
                end
                iuds_pkg::OP_CF_START:
                begin
                    seq_reg    <= seq_reg + 4'd1;
                    st_off_reg <= 3'd1;
                    st_cnt_reg <= 3'd0;
                    st_n_reg   <= 3'd7;
                end
                iuds_pkg::OP_CLR_EXP:
                begin
                    expected_reg <= '0;
                end
                iuds_pkg::OP_STORE:
                begin
                    if (widx_reg < iuds_pkg::WIDX_MAX)
                    begin
                        widx_reg <= widx_reg + 9'd1;
                    end
                    st_cnt_reg <= st_cnt_reg + 3'd1;
                end
                iuds_pkg::OP_SERVE_START:
                begin
                    len_reg      <= serve_len;
                    src_sf_reg   <= cmd.src_sf;
                    expected_reg <= '0;
                    if (serve_len != 8'd0)
                    begin
                        widx_reg <= '0;
                    end
                end
                iuds_pkg::OP_SET_S1:
                begin
                    session_reg <= iuds_pkg::SESS_ACTIVE;
                end
                iuds_pkg::OP_DL_ACCEPT:
                begin
                    session_reg <= iuds_pkg::SESS_DL;
                    waddr_reg   <= dl_addr;
                    bc_reg      <= 8'd1;
                end
                iuds_pkg::OP_TD_START:
                begin
                    n_reg       <= len_reg - 8'd2;
                    pending_reg <= len_reg - 8'd2;
                    k_reg       <= '0;
                end
                iuds_pkg::OP_CHUNK_RD:
                begin
                    ck_cnt_reg <= ck_cnt;
                end
                iuds_pkg::OP_CHUNK_NEXT:
                begin
                    k_reg <= k_reg + 9'd8;
                end
                iuds_pkg::OP_FLOW_DONE:
                begin
                    if (expected_reg > iuds_pkg::MAX_REQ_LEN)
                    begin
                        expected_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Buffer reader control: issue one address per cycle, capture it in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_busy_reg   <= 1'b0;
            rd_hdr_reg    <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_total_reg  <= '0;
            rd_base_reg   <= '0;
            cap_valid_reg <= 1'b0;
            cap_slot_reg  <= '0;
            cap_idx_reg   <= '0;
        end
        else
        begin
            cap_valid_reg <= rd_busy_reg;
            if (rd_busy_reg)
            begin
                cap_slot_reg <= rd_cnt_reg;
                cap_idx_reg  <= rd_idx;
                rd_cnt_reg   <= rd_cnt_reg + 4'd1;
                if (rd_cnt_reg == rd_total_reg - 4'd1)
                begin
                    rd_busy_reg <= 1'b0;
                end
            end
            else if (cmd.op == iuds_pkg::OP_SERVE_START && serve_len != 8'd0)
            begin
                rd_busy_reg  <= 1'b1;
                rd_hdr_reg   <= 1'b1;
                rd_cnt_reg   <= '0;
                rd_total_reg <= 4'd11;
                rd_base_reg  <= 8'd0;
            end
            else if (cmd.op == iuds_pkg::OP_CHUNK_RD)
            begin
                rd_busy_reg  <= 1'b1;
                rd_hdr_reg   <= 1'b0;
                rd_cnt_reg   <= '0;
                rd_total_reg <= ck_cnt;
                rd_base_reg  <= k_reg[7:0] + 8'd2;
            end
        end
    end

    // Captured bytes, latched frame and the download range check.
    always_ff @(posedge clk)
    begin
        if (cmd.op == iuds_pkg::OP_LATCH)
        begin
            action_reg <= action_in;
            for (int i = 0; i < 8; i++)
            begin
                frame_reg[i] <= frame_in[i];
            end
        end
        if (cmd.op == iuds_pkg::OP_CHUNK_RD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chunk_reg[i] <= 8'h00;
            end
        end
        else if (cap_valid_reg && !rd_hdr_reg)
        begin
            chunk_reg[cap_slot_reg[2:0]] <= cap_data;
        end
        if (cap_valid_reg && rd_hdr_reg)
        begin
            hdr_reg[cap_slot_reg] <= cap_data;
        end
        range_ok_reg <= (dl_addr >= start_reg) && (dl_addr <= end_reg) &&
                        (dl_end <= {1'b0, end_reg});
    end

    // Result stages: a holding stage decides which result is the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else if (cmd.emit)
        begin
            hold_v_reg <= 1'b1;
            if (hold_v_reg)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
        else if (cmd.op == iuds_pkg::OP_FINISH && hold_v_reg)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    // The held result is the last one when the item finishes instead of emitting more.
    always_comb
    begin
        fwd      = hold_reg;
        fwd.last = !cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hold_reg <= built;
            if (hold_v_reg)
            begin
                out_reg <= fwd;
            end
        end
        else if (cmd.op == iuds_pkg::OP_FINISH && hold_v_reg)
        begin
            out_reg <= fwd;
        end
    end

    assign out_res   = out_reg;
    assign out_valid = out_v_reg;

endmodule

>>> rtl/isotp_uds_download_server.sv
`timescale 1ns / 1ps

// ISO-TP receiver and UDS flash download server.
// The req channel carries one item per received CAN frame (action 0) or per
// flash write-done event (action 1). The rsp channel carries the results: tx
// frames, unlock, erase, write chunk, transfer exit and reset commands; last
// marks the final result of an input item. The cfg channel writes the four
// setup registers and is always ready; write it only while the block is idle.
// Items are handled one at a time. A frame that stores into the receive buffer
// writes its bytes into it one by one; a served request reads its header and
// then each 8-byte write chunk one byte per cycle, from the receive buffer or,
// for a single frame, from the bytes of the frame itself, which stay latched.
// Results pass through a holding stage and an output register, so the next item
// is accepted while the final result of the previous one still waits.
// When the receiver stalls, the block stops at the next result and waits.
// Reset returns the control, configuration and protocol registers to their defaults
// and clears the session; the buffer contents are undefined until frames are stored.
module isotp_uds_download_server #(
    parameter int BUFFER_BYTES = iuds_pkg::BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    iuds_req_if.sink    req,
    iuds_rsp_if.source  rsp,
    iuds_cfg_if.sink    cfg
);

    iuds_pkg::cmd_t   cmd;
    iuds_pkg::sts_t   sts;
    iuds_pkg::res_t   out_res;
    logic [7:0][7:0]  frame;

    assign frame = {req.frame_byte7, req.frame_byte6, req.frame_byte5, req.frame_byte4,
                    req.frame_byte3, req.frame_byte2, req.frame_byte1, req.frame_byte0};
    assign cfg.ready = 1'b1;

    // Controller.
    iuds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    iuds_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .action_in (req.action),
        .frame_in  (frame),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_res   (out_res),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready)
    );

    // Result fields.
    assign rsp.kind           = out_res.kind;
    assign rsp.out_byte0      = out_res.data[0];
    assign rsp.out_byte1      = out_res.data[1];
    assign rsp.out_byte2      = out_res.data[2];
    assign rsp.out_byte3      = out_res.data[3];
    assign rsp.out_byte4      = out_res.data[4];
    assign rsp.out_byte5      = out_res.data[5];
    assign rsp.out_byte6      = out_res.data[6];
    assign rsp.out_byte7      = out_res.data[7];
    assign rsp.byte_count     = out_res.cnt;
    assign rsp.target_address = out_res.addr;
    assign rsp.last           = out_res.last;

    // A result is only pushed when the result stages have room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.can_push)
        else $error("result pushed without room");

    // No result of a finished item lingers in the holding stage.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !sts.hold_valid)
        else $error("holding stage busy while idle");

    // An accepted item is not followed by another acceptance in the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("two items accepted back to back");

endmodule
